// ===== design/pst_pkg.sv =====
// Shared types and codes for the potentiometer offset trim block.
package pst_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int CODE_BITS_DEF   = 8;
	localparam int REF_BITS        = 12;
	localparam int STEP_BITS       = 16;

	localparam logic [REF_BITS-1:0] REF_RESET = 12'd2048;

	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_WR_DONE = 2'd1;
	localparam logic [1:0] OP_SAMPLE  = 2'd2;

	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_SAMPLE = 2'd1;
	localparam logic [1:0] ACT_DONE   = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic        write_ok;
		logic [11:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  wiper_value;
		logic        success;
		logic [15:0] step_offset;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} pst_res_t;

endpackage

// ===== design/pst_in_stage.sv =====
// Input register stage: holds one accepted transaction for the control logic.
module pst_in_stage
	import pst_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     advance,
	output logic     valid_s1,
	output in_item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

endmodule

// ===== design/pst_ctrl.sv =====
// Calibration sequencer: step measurement and successive-approximation search.
module pst_ctrl
	import pst_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CODE_BITS   = CODE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [REF_BITS-1:0] cfg_wdata,
	input  logic                advance,
	input  in_item_t            item_s1,
	output pst_res_t            res
);

	localparam int SW = (SAMPLE_BITS < 12) ? SAMPLE_BITS : 12;
	localparam int CW = CODE_BITS;
	localparam int BW = $clog2(CODE_BITS);
	localparam logic [CW-1:0] TOP_CODE = CW'(1) << (CODE_BITS - 1);
	localparam logic [CW-1:0] TOP_CODE_P1 = TOP_CODE + CW'(1);
	localparam logic [BW-1:0] BIT_TOP = BW'(CODE_BITS - 1);

	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_WR_LOW     = 3'd1;
	localparam logic [2:0] PH_SMP_LOW    = 3'd2;
	localparam logic [2:0] PH_WR_HIGH    = 3'd3;
	localparam logic [2:0] PH_SMP_HIGH   = 3'd4;
	localparam logic [2:0] PH_WR_SEARCH  = 3'd5;
	localparam logic [2:0] PH_SMP_SEARCH = 3'd6;

	logic [REF_BITS-1:0]  reference_q;
	logic [2:0]           phase_q, phase_n;
	logic [CW-1:0]        code_q, code_n;
	logic [BW-1:0]        bit_q, bit_n;
	logic [SW-1:0]        first_q, first_n;
	logic [STEP_BITS-1:0] step_q, step_n;
	logic                 fin_q, fin_n;

	logic [SW-1:0]        smp;
	logic [STEP_BITS-1:0] smp_ext, ref_ext, tol, above_diff, below_diff;
	logic [BW-1:0]        bit_dec;
	logic [CW-1:0]        code_clr, set_dec;
	logic                 res_vld, res_ok;
	logic [1:0]           res_act;

	assign smp        = item_s1.sample_value[SW-1:0];
	assign smp_ext    = STEP_BITS'(smp);
	assign ref_ext    = STEP_BITS'(reference_q);
	assign tol        = step_q >> 1;
	assign above_diff = smp_ext - ref_ext;
	assign below_diff = ref_ext - smp_ext;
	assign bit_dec    = bit_q - BW'(1);
	assign code_clr   = code_q & ~(CW'(1) << bit_q);
	assign set_dec    = CW'(1) << bit_dec;

	always_comb begin
		phase_n = phase_q;
		code_n  = code_q;
		bit_n   = bit_q;
		first_n = first_q;
		step_n  = step_q;
		fin_n   = fin_q;
		res_vld = 1'b0;
		res_act = ACT_WRITE;
		res_ok  = 1'b0;
		unique case (item_s1.operation)
			OP_START: begin
				code_n  = TOP_CODE;
				bit_n   = BIT_TOP;
				first_n = '0;
				step_n  = '0;
				fin_n   = 1'b0;
				phase_n = PH_WR_LOW;
				res_vld = 1'b1;
			end
			OP_WR_DONE: begin
				if (phase_q inside {PH_WR_LOW, PH_WR_HIGH, PH_WR_SEARCH}) begin
					res_vld = 1'b1;
					if (!item_s1.write_ok || fin_q) begin
						phase_n = PH_IDLE;
						fin_n   = 1'b0;
						res_act = ACT_DONE;
						res_ok  = item_s1.write_ok;
					end else begin
						phase_n = phase_q + 3'd1;
						res_act = ACT_SAMPLE;
					end
				end
			end
			OP_SAMPLE: begin
				unique case (phase_q)
					PH_SMP_LOW: begin
						first_n = smp;
						code_n  = TOP_CODE_P1;
						phase_n = PH_WR_HIGH;
						res_vld = 1'b1;
					end
					PH_SMP_HIGH: begin
						step_n  = smp_ext - STEP_BITS'(first_q);
						bit_n   = BIT_TOP;
						code_n  = TOP_CODE;
						phase_n = PH_WR_SEARCH;
						res_vld = 1'b1;
					end
					PH_SMP_SEARCH: begin
						res_vld = 1'b1;
						if (smp_ext > ref_ext && above_diff > tol) begin
							phase_n = PH_WR_SEARCH;
							if (bit_q == '0) begin
								code_n = code_clr;
								fin_n  = 1'b1;
							end else begin
								bit_n  = bit_dec;
								code_n = code_clr | set_dec;
							end
						end else if (smp_ext < ref_ext && below_diff > tol && bit_q != '0) begin
							bit_n   = bit_dec;
							code_n  = code_q | set_dec;
							phase_n = PH_WR_SEARCH;
						end else begin
							phase_n = PH_IDLE;
							fin_n   = 1'b0;
							res_act = ACT_DONE;
							res_ok  = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.valid            = res_vld;
		res.item.action      = res_act;
		res.item.wiper_value = 8'(code_n);
		res.item.success     = res_ok;
		res.item.step_offset = step_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_q <= REF_RESET;
		end else if (cfg_we) begin
			reference_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			code_q  <= '0;
			bit_q   <= BIT_TOP;
			first_q <= '0;
			step_q  <= '0;
			fin_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			code_q  <= code_n;
			bit_q   <= bit_n;
			first_q <= first_n;
			step_q  <= step_n;
			fin_q   <= fin_n;
		end
	end

endmodule

// ===== design/pst_out_stage.sv =====
// Result register: holds one result transaction until the consumer takes it.
module pst_out_stage
	import pst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  pst_res_t  res,
	input  logic      out_ready,
	output logic      out_valid,
	output out_item_t out_data,
	output logic      slot_free
);

	logic      valid_q;
	out_item_t data_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res.valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			data_q <= res.item;
		end
	end

endmodule

// ===== design/pot_sar_offset_trim.sv =====
// Top level of the potentiometer offset trim sequencer.
// An accepted transaction waits in the input register, its result in the result
// register. Throughput: one input transaction per cycle while results are taken;
// the two registers let a new transaction enter while a result waits.
// Reset: asynchronous, active low; clears the sequencer to idle, the wiper code
// to zero, the bit pointer to the top bit and the reference level to 2048.
module pot_sar_offset_trim
	import pst_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CODE_BITS   = CODE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [REF_BITS-1:0] cfg_wdata
);

	logic     valid_s1;
	in_item_t item_s1;
	logic     slot_free;
	logic     advance;
	pst_res_t res;

	assign advance = valid_s1 && slot_free;

	pst_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pst_ctrl #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.CODE_BITS   (CODE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.item_s1   (item_s1),
		.res       (res)
	);

	pst_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.slot_free (slot_free)
	);

endmodule

// ===== design/pst_checker.sv =====
// Port-level checker for the offset trim block, bound to the top level.
module pst_checker
	import pst_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result transaction changed while stalled");

	a_success_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.action != ACT_DONE |-> !out_data.success)
		else $error("success flagged on a non-finish result");

	a_no_input_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty result register");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input transaction changed while stalled");

endmodule

bind pot_sar_offset_trim pst_checker u_pst_checker (.*);
